>>> design/pass_pkg.sv
// Package for the profile address sorted set: sequencer states, status and
// mode codes, the compare result type and the address encoder.
// Self-contained; used by pass_cmp and the top level.
package pass_pkg;

  localparam int unsigned DEFAULT_DEPTH = 1024;
  localparam int unsigned CODE_W        = 16;
  localparam int unsigned COUNT_OUT_W   = 11;

  localparam logic [7:0]        TEXT_TYPE = 8'd34;
  localparam logic [CODE_W-1:0] OVL_FLAG  = 16'h8000;
  localparam logic [CODE_W-1:0] OVL_BASE  = 16'hE000;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_OK      = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_WRITE  = 5'b01000,
    S_READ   = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic lt;  // table entry below the new code
    logic eq;  // table entry equal to the new code
  } cmp_t;

  function automatic logic [CODE_W-1:0] encode_code(input logic [7:0]        ovno,
                                                    input logic [CODE_W-1:0] value);
    logic [CODE_W-1:0] off;
    off = value - OVL_BASE;
    if (ovno != 8'd0) begin
      encode_code = OVL_FLAG | {ovno[3:0], 12'h000} | {1'b0, off[CODE_W-1:1]};
    end else begin
      encode_code = {1'b0, value[CODE_W-1:1]};
    end
  endfunction

endpackage

>>> design/pass_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pass_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pass_cmp.sv
// Shared magnitude comparator used by the sequencer for every search step.
// Depends on pass_pkg for the compare result type.
module pass_cmp (
  input  logic [pass_pkg::CODE_W-1:0] entry_i,
  input  logic [pass_pkg::CODE_W-1:0] code_i,
  output pass_pkg::cmp_t              cmp_o
);
  import pass_pkg::*;

  always_comb begin
    cmp_o.lt = (entry_i < code_i);
    cmp_o.eq = (entry_i == code_i);
  end

endmodule

>>> design/profile_address_sorted_set.sv
// Profile address sorted set: top level with the insertion sequencer.
// Depends on pass_pkg, pass_ram and pass_cmp.
//
// Keeps an ascending set of distinct 16-bit profile codes built from symbol
// records; index 0 always stands for code zero. An insert of a new code
// scans entries from index 1 up to the insertion point, moves the entries
// above it up one place and then writes the code; the scan and the shift
// each use the single RAM read port once per cycle. An insert that finds its
// code already held ends at the matching entry. A read passes through S_READ
// for the registered RAM read; clear and requests refused at once are
// answered from idle. Clear only resets the entry count, so there is no
// clearing pass after reset. The input stalls while a request is in work and
// while a finished result waits on a stalled output.
module profile_address_sorted_set #(
  parameter int unsigned TABLE_DEPTH = pass_pkg::DEFAULT_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       mode_i,
  input  logic [7:0]                       sym_type_i,
  input  logic [7:0]                       overlay_number_i,
  input  logic [pass_pkg::CODE_W-1:0]      sym_value_i,
  input  logic [9:0]                       read_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pass_pkg::CODE_W-1:0]      entry_value_o,
  output logic [pass_pkg::COUNT_OUT_W-1:0] entry_count_o,
  output logic [2:0]                       status_o
);
  import pass_pkg::*;

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > 10) ? CW : 10;

  seq_state_e        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     k_q, k_d;
  logic [AW-1:0]     s_q, s_d;
  logic              rd_zero_q, rd_zero_d;

  logic                   out_valid_q, out_valid_d;
  logic [CODE_W-1:0]      entry_value_q;
  logic [COUNT_OUT_W-1:0] entry_count_q;
  logic [2:0]             status_q;

  logic              load_out;
  logic [CODE_W-1:0] res_value;
  logic [CW-1:0]     res_count;
  logic [2:0]        res_status;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CODE_W-1:0] ram_rdata;
  cmp_t              cmp;

  logic              accept;
  logic [CODE_W-1:0] code_in;
  logic              is_text;
  logic              is_full;
  logic              idx_ok;

  pass_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pass_cmp u_cmp (
    .entry_i (ram_rdata),
    .code_i  (code_q),
    .cmp_o   (cmp)
  );

  // A new request is taken only when the result slot will be free next cycle.
  assign in_stall_o = (state_q != S_IDLE) | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign code_in    = encode_code(overlay_number_i, sym_value_i);
  assign is_text    = (sym_type_i == TEXT_TYPE);
  assign is_full    = (cnt_q == CW'(TABLE_DEPTH));
  assign idx_ok     = (CMPW'(read_index_i) < CMPW'(cnt_q));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    code_d     = code_q;
    pos_d      = pos_q;
    k_d        = k_q;
    s_d        = s_q;
    rd_zero_d  = rd_zero_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    load_out   = 1'b0;
    res_value  = '0;
    res_count  = cnt_q;
    res_status = ST_IGNORED;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_INSERT: begin
              code_d = code_in;
              if (is_full) begin
                load_out   = 1'b1;
                res_value  = is_text ? code_in : '0;
                res_status = ST_FULL;
              end else if (!is_text) begin
                load_out   = 1'b1;
                res_status = ST_IGNORED;
              end else if (code_in == '0) begin
                // Zero is always held at index 0.
                load_out   = 1'b1;
                res_value  = code_in;
                res_status = ST_IGNORED;
              end else if (cnt_q == CW'(1)) begin
                pos_d   = AW'(1);
                state_d = S_WRITE;
              end else begin
                s_d       = AW'(1);
                ram_raddr = AW'(1);
                state_d   = S_SEARCH;
              end
            end
            MODE_READ: begin
              if (idx_ok) begin
                ram_raddr = AW'(read_index_i);
                rd_zero_d = (read_index_i == 10'd0);
                state_d   = S_READ;
              end else begin
                load_out   = 1'b1;
                res_status = ST_RANGE;
              end
            end
            MODE_CLEAR: begin
              cnt_d      = CW'(1);
              load_out   = 1'b1;
              res_count  = CW'(1);
              res_status = ST_OK;
            end
            default: begin
              load_out   = 1'b1;
              res_status = ST_IGNORED;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (cmp.eq) begin
          load_out   = 1'b1;
          res_value  = code_q;
          res_status = ST_IGNORED;
          state_d    = S_IDLE;
        end else if (!cmp.lt) begin
          pos_d     = s_q;
          k_d       = AW'(cnt_q - CW'(1));
          ram_raddr = AW'(cnt_q - CW'(1));
          state_d   = S_SHIFT;
        end else if ((CW'(s_q) + CW'(1)) == cnt_q) begin
          pos_d   = AW'(cnt_q);
          state_d = S_WRITE;
        end else begin
          s_d       = s_q + AW'(1);
          ram_raddr = s_q + AW'(1);
        end
      end
      S_SHIFT: begin
        // Move the entry read last cycle up one place, top entry first.
        ram_we    = 1'b1;
        ram_waddr = k_q + AW'(1);
        ram_wdata = ram_rdata;
        if (k_q == pos_q) begin
          state_d = S_WRITE;
        end else begin
          k_d       = k_q - AW'(1);
          ram_raddr = k_q - AW'(1);
        end
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_q;
        ram_wdata  = code_q;
        cnt_d      = cnt_q + CW'(1);
        load_out   = 1'b1;
        res_value  = code_q;
        res_count  = cnt_q + CW'(1);
        res_status = ST_ADDED;
        state_d    = S_IDLE;
      end
      S_READ: begin
        load_out   = 1'b1;
        res_value  = rd_zero_q ? '0 : ram_rdata;
        res_status = ST_OK;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    pos_q     <= pos_d;
    k_q       <= k_d;
    s_q       <= s_d;
    rd_zero_q <= rd_zero_d;
    if (load_out) begin
      entry_value_q <= res_value;
      entry_count_q <= COUNT_OUT_W'(res_count);
      status_q      <= res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = entry_value_q;
  assign entry_count_o = entry_count_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CW'(TABLE_DEPTH)))
    else $error("entry count left its range");

  a_keep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr != '0))
    else $error("write to the entry that holds code zero");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled result");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (k_q >= pos_q))
    else $error("shift pointer passed the insertion point");
`endif

endmodule
